// ----- hdl/cad_lbt_pkg.sv -----
// Shared constants, codes and controller/datapath handshake types for the LBT backoff block.
package cad_lbt_pkg;

    // Default width of the wrapping millisecond time base
    localparam int TIME_BITS_DEF = 32;

    // Field and register widths
    localparam int ACT_W      = 2;
    localparam int OUTCOME_W  = 2;
    localparam int STEP_W     = 2;
    localparam int MODE_W     = 2;
    localparam int NOW_W      = 32;
    localparam int RND_W      = 32;
    localparam int CNT_W      = 8;
    localparam int ERR_W      = 32;
    localparam int MAXW       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_CNT_W  = $clog2(RND_W);

    // Item actions
    localparam logic [ACT_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POLL   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DETECT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FINISH = 2'd3;

    // Detection outcomes (anything other than free or busy counts as an error)
    localparam logic [OUTCOME_W-1:0] OUT_FREE = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_BUSY = 2'd1;

    // Reported step
    localparam logic [STEP_W-1:0] STEP_IDLE     = 2'd0;
    localparam logic [STEP_W-1:0] STEP_WAIT     = 2'd1;
    localparam logic [STEP_W-1:0] STEP_DETECT   = 2'd2;
    localparam logic [STEP_W-1:0] STEP_TRANSMIT = 2'd3;

    // Access modes
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAITING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MAX = 1'b1;

    // Register reset values
    localparam logic [CNT_W-1:0] RETRY_LIMIT_RST = 8'd3;
    localparam logic [MAXW-1:0]  BACKOFF_MAX_RST = 16'd1000;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;      // capture the input item
        logic div_start;  // load the remainder unit
        logic div_step;   // one restoring step
        logic commit;     // update state and result registers
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;   // item draws a random wait
        logic div_last;   // final remainder step this cycle
    } t_stat;

endpackage

// ----- hdl/cad_listen_before_talk_backoff.sv -----
// Top level of the listen-before-talk random backoff block.
// Listen-before-talk access control with random backoff. Each item (start, poll, detection
// result, finish) gives exactly one result item. Items are handled one at a time: each is
// latched, evaluated and committed to the result registers; a detection result that backs off
// with a nonzero maximum also runs the 32-step restoring remainder unit, which reduces
// random_word modulo backoff_max, before the commit. A finished result sits in the output
// register while the next item is accepted; the following result waits in the controller
// until the previous one is taken. Configuration writes take effect immediately; the user
// must make them only while no item is in flight, the block itself does not enforce this.
module cad_listen_before_talk_backoff #(
    parameter int TIME_BITS = cad_lbt_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cad_lbt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cad_lbt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [cad_lbt_pkg::ACT_W-1:0]        i_action,
    input  logic [cad_lbt_pkg::NOW_W-1:0]        i_now_time,
    input  logic [cad_lbt_pkg::OUTCOME_W-1:0]    i_detect_outcome,
    input  logic [cad_lbt_pkg::RND_W-1:0]        i_random_word,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [cad_lbt_pkg::STEP_W-1:0]       o_tx_step,
    output logic                                 o_forced_tx,
    output logic [cad_lbt_pkg::CNT_W-1:0]        o_backoff_total,
    output logic [cad_lbt_pkg::ERR_W-1:0]        o_error_total,
    output logic                                 o_busy_backoff_event
);
    import cad_lbt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencing and handshake
    cad_lbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // State, timer compare and remainder unit
    cad_lbt_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_action             (i_action),
        .i_now_time           (i_now_time),
        .i_detect_outcome     (i_detect_outcome),
        .i_random_word        (i_random_word),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .o_tx_step            (o_tx_step),
        .o_forced_tx          (o_forced_tx),
        .o_backoff_total      (o_backoff_total),
        .o_error_total        (o_error_total),
        .o_busy_backoff_event (o_busy_backoff_event)
    );

endmodule

// ----- hdl/cad_lbt_ctrl.sv -----
// Controller state machine: input/output handshake and sequencing of the datapath.
module cad_lbt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  cad_lbt_pkg::t_stat  i_stat,
    output cad_lbt_pkg::t_cmd   o_cmd
);
    import cad_lbt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    // Result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- hdl/cad_lbt_dp.sv -----
// Datapath: configuration, access state, wait timer compare and iterative remainder unit.
module cad_lbt_dp #(
    parameter int TIME_BITS = cad_lbt_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cad_lbt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cad_lbt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [cad_lbt_pkg::ACT_W-1:0]        i_action,
    input  logic [cad_lbt_pkg::NOW_W-1:0]        i_now_time,
    input  logic [cad_lbt_pkg::OUTCOME_W-1:0]    i_detect_outcome,
    input  logic [cad_lbt_pkg::RND_W-1:0]        i_random_word,
    input  cad_lbt_pkg::t_cmd                    i_cmd,
    output cad_lbt_pkg::t_stat                   o_stat,
    output logic [cad_lbt_pkg::STEP_W-1:0]       o_tx_step,
    output logic                                 o_forced_tx,
    output logic [cad_lbt_pkg::CNT_W-1:0]        o_backoff_total,
    output logic [cad_lbt_pkg::ERR_W-1:0]        o_error_total,
    output logic                                 o_busy_backoff_event
);
    import cad_lbt_pkg::*;

    localparam int CMP_W = (TIME_BITS > MAXW) ? TIME_BITS : MAXW;

    // Configuration
    logic [CNT_W-1:0]     r_retry_limit;
    logic [MAXW-1:0]      r_backoff_max;
    // Captured item
    logic [ACT_W-1:0]     r_action;
    logic [TIME_BITS-1:0] r_now;
    logic [OUTCOME_W-1:0] r_outcome;
    logic [RND_W-1:0]     r_rnd;
    // Access state
    logic [MODE_W-1:0]    r_mode,   n_mode;
    logic [TIME_BITS-1:0] r_origin, n_origin;
    logic [MAXW-1:0]      r_wlen,   n_wlen;
    logic [CNT_W-1:0]     r_bcnt,   n_bcnt;
    logic                 r_forced, n_forced;
    logic [ERR_W-1:0]     r_errs,   n_errs;
    // Result-only registers
    logic [STEP_W-1:0]    r_step,   n_step;
    logic                 r_busy,   n_busy;
    // Remainder unit
    logic [RND_W-1:0]     r_quo;
    logic [MAXW-1:0]      r_rem;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [MAXW:0]        w_rem_sh;
    logic [MAXW:0]        w_rem_sub;
    logic                 w_rem_ge;
    // Decision terms
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_waited;
    logic [STEP_W-1:0]    w_poll_step;
    logic                 w_active;
    logic                 w_free;
    logic                 w_limit;
    logic                 w_backoff;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RST;
            r_backoff_max <= BACKOFF_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[CNT_W-1:0];
                REG_BACKOFF_MAX: r_backoff_max <= i_cfg_wdata[MAXW-1:0];
            endcase
        end
    end

    // Item capture; time folded to the configured time base
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action  <= i_action;
            r_now     <= TIME_BITS'(i_now_time);
            r_outcome <= i_detect_outcome;
            r_rnd     <= i_random_word;
        end
    end

    // Wait elapsed: wrapping difference against the wait length
    assign w_elapsed = r_now - r_origin;
    assign w_waited  = CMP_W'(w_elapsed) >= CMP_W'(r_wlen);

    always_comb begin
        case (r_mode)
            MODE_IDLE:  w_poll_step = STEP_IDLE;
            MODE_READY: w_poll_step = STEP_TRANSMIT;
            default:    w_poll_step = w_waited ? STEP_DETECT : STEP_WAIT;
        endcase
    end

    // Backoff decision
    assign w_active  = (r_mode != MODE_IDLE);
    assign w_free    = (r_outcome == OUT_FREE);
    assign w_limit   = (r_bcnt >= r_retry_limit);
    assign w_backoff = (r_action == ACT_DETECT) && w_active && !w_free && !w_limit;

    assign o_stat.need_div = w_backoff && (r_backoff_max != '0);
    assign o_stat.div_last = (r_dcnt == '1);

    // Restoring remainder, one dividend bit per step
    assign w_rem_sh  = {r_rem, r_quo[RND_W-1]};
    assign w_rem_ge  = w_rem_sh >= {1'b0, r_backoff_max};
    assign w_rem_sub = w_rem_sh - {1'b0, r_backoff_max};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo  <= r_rnd;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[RND_W-2:0], 1'b0};
            r_rem  <= w_rem_ge ? w_rem_sub[MAXW-1:0] : w_rem_sh[MAXW-1:0];
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Item update
    always_comb begin
        n_mode   = r_mode;
        n_origin = r_origin;
        n_wlen   = r_wlen;
        n_bcnt   = r_bcnt;
        n_forced = r_forced;
        n_errs   = r_errs;
        n_step   = STEP_IDLE;
        n_busy   = 1'b0;
        case (r_action)
            ACT_START: begin
                n_mode   = MODE_WAITING;
                n_origin = r_now;
                n_wlen   = '0;
                n_bcnt   = '0;
                n_forced = 1'b0;
                // zero wait has always elapsed
                n_step   = STEP_DETECT;
            end
            ACT_POLL: begin
                n_step = w_poll_step;
            end
            ACT_DETECT: begin
                if (!w_active) begin
                    n_step = STEP_IDLE;
                end else if (w_free) begin
                    n_mode = MODE_READY;
                    n_step = STEP_TRANSMIT;
                end else if (w_limit) begin
                    n_forced = 1'b1;
                    n_mode   = MODE_READY;
                    n_step   = STEP_TRANSMIT;
                end else begin
                    n_bcnt = r_bcnt + 1'b1;
                    if (r_outcome == OUT_BUSY) begin
                        n_busy = 1'b1;
                    end else begin
                        n_errs = r_errs + 1'b1;
                    end
                    n_wlen   = o_stat.need_div ? r_rem : '0;
                    n_origin = r_now;
                    n_mode   = MODE_WAITING;
                    n_step   = STEP_WAIT;
                end
            end
            ACT_FINISH: begin
                n_mode = MODE_IDLE;
                n_step = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_origin <= '0;
            r_wlen   <= '0;
            r_bcnt   <= '0;
            r_forced <= 1'b0;
            r_errs   <= '0;
        end else if (i_cmd.commit) begin
            r_mode   <= n_mode;
            r_origin <= n_origin;
            r_wlen   <= n_wlen;
            r_bcnt   <= n_bcnt;
            r_forced <= n_forced;
            r_errs   <= n_errs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

    // State is only updated on commit, so it doubles as the result
    assign o_tx_step            = r_step;
    assign o_busy_backoff_event = r_busy;
    assign o_forced_tx          = r_forced;
    assign o_backoff_total      = r_bcnt;
    assign o_error_total        = r_errs;

endmodule
